### src/assert_macros.svh
// Assertion macros used by the checker file of the SipHash block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SIP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Trigger implies the consequent on the next clock edge.
`define SIP_ASSERT_NEXT(label, clk, rstn, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cons)) \
        else $error(msg);

`endif

### src/sip_pkg.sv
// Types, constants and round functions shared by the SipHash block.
package sip_pkg;

    // Lane initialization constants.
    localparam logic [63:0] INIT_C0 = 64'h736f6d6570736575;
    localparam logic [63:0] INIT_C1 = 64'h646f72616e646f6d;
    localparam logic [63:0] INIT_C2 = 64'h6c7967656e657261;
    localparam logic [63:0] INIT_C3 = 64'h7465646279746573;
    localparam logic [63:0] FINAL_MARK = 64'h00000000000000ff;

    // Round counts saturate at this value.
    localparam int MAX_ROUNDS = 8;
    localparam int ROUND_W = $clog2(MAX_ROUNDS + 1);
    localparam int CFG_ROUND_W = 4;

    // Stream and configuration widths.
    localparam int WORD_W = 64;
    localparam int TAIL_W = 3;
    localparam int IN_TDATA_W = 72;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_W = 8;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMP_ROUNDS = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIN_ROUNDS = 8'd3;

    // Queue between the front and back parts; depth is a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // The four state lanes.
    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } lanes_t;

    // One message block ready for compression.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } blk_t;

    // Queue status seen by the back part.
    typedef struct packed {
        logic empty;
        blk_t head;
    } q_status_t;

    // Configuration write beat.
    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int s);
        return (x << s) | (x >> (64 - s));
    endfunction

    // One SipRound over all four lanes.
    function automatic lanes_t sip_round(input lanes_t a);
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
        lanes_t r;
        v0 = a.v0 + a.v1;
        v1 = rotl(a.v1, 13) ^ v0;
        v0 = rotl(v0, 32);
        v2 = a.v2 + a.v3;
        v3 = rotl(a.v3, 16) ^ v2;
        v0 = v0 + v3;
        v3 = rotl(v3, 21) ^ v0;
        v2 = v2 + v1;
        v1 = rotl(v1, 17) ^ v2;
        v2 = rotl(v2, 32);
        r.v0 = v0;
        r.v1 = v1;
        r.v2 = v2;
        r.v3 = v3;
        return r;
    endfunction

    // Lanes loaded from the key.
    function automatic lanes_t lanes_init(input logic [63:0] k0, input logic [63:0] k1);
        lanes_t r;
        r.v0 = k0 ^ INIT_C0;
        r.v1 = k1 ^ INIT_C1;
        r.v2 = k0 ^ INIT_C2;
        r.v3 = k1 ^ INIT_C3;
        return r;
    endfunction

    // Round count clipped to the supported maximum.
    function automatic logic [ROUND_W-1:0] sat_rounds(input logic [CFG_ROUND_W-1:0] n);
        logic [ROUND_W-1:0] r;
        if (int'(n) > MAX_ROUNDS)
        begin
            r = ROUND_W'(MAX_ROUNDS);
        end
        else
        begin
            r = ROUND_W'(n);
        end
        return r;
    endfunction

endpackage

### src/siphash_keyed_hash_top.sv
// Each word runs its c compression rounds in the back part (c = compression rounds, clipped to 8),
// one SipRound per cycle through a single shared round unit; a 2-beat queue lets input run ahead.
// The final word then runs its d finalization rounds into the output register.
// Reset clears the queue, the length count and the result; keys read zero, c=2, d=4, and
// the lanes hold the zero-key initial values.
module siphash_keyed_hash_top (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input stream: tdata = message_word[63:0], tail_bytes[66:64], zero fill to 71.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [sip_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tlast,
    // Result stream: tdata = hash_value[63:0].
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [sip_pkg::WORD_W-1:0]       m_axis_tdata,
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sip_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sip_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sip_pkg::*;

    cfg_wr_t   cfg;
    q_status_t q_status;
    blk_t      push_blk;
    logic      push;
    logic      pop;
    logic      q_full;
    logic      key_write;

    // Configuration beats are always taken.
    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data = cfg_data;
    assign key_write = cfg_valid && (cfg_index == REG_KEY_LOW || cfg_index == REG_KEY_HIGH);

    sip_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_data    (s_axis_tdata),
        .s_last    (s_axis_tlast),
        .len_clear (key_write),
        .q_full    (q_full),
        .push      (push),
        .blk       (push_blk)
    );

    sip_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_blk (push_blk),
        .pop      (pop),
        .full     (q_full),
        .status   (q_status)
    );

    sip_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_hash  (m_axis_tdata)
    );

endmodule

### src/sip_front.sv
// Front part: accepts message beats, pads the final word and tracks the length.
module sip_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [sip_pkg::IN_TDATA_W-1:0] s_data,
    input  logic                           s_last,
    input  logic                           len_clear,
    input  logic                           q_full,
    output logic                           push,
    output sip_pkg::blk_t                  blk
);
    import sip_pkg::*;

    logic [LEN_W-1:0]  length_reg;
    logic [LEN_W-1:0]  length_next;
    logic [WORD_W-1:0] word;
    logic [TAIL_W-1:0] tail;
    logic [WORD_W-1:0] mask;
    logic [LEN_W-1:0]  total;

    assign word = s_data[WORD_W-1:0];
    assign tail = s_data[WORD_W +: TAIL_W];
    assign s_ready = !q_full;
    assign push = s_valid && !q_full;

    // Byte mask of the valid tail bytes.
    always_comb
    begin
        for (int b = 0; b < WORD_W / 8; b++)
        begin
            mask[b*8 +: 8] = (b < int'(tail)) ? 8'hff : 8'h00;
        end
    end

    // Final word carries the length modulo 256 in its top byte.
    assign total = length_reg + LEN_W'(tail);

    always_comb
    begin
        if (s_last)
        begin
            blk.word = (word & mask) | {total, {(WORD_W - LEN_W){1'b0}}};
        end
        else
        begin
            blk.word = word;
        end
        blk.last = s_last;
    end

    // Running length count, cleared at the end of a message or on a key write.
    always_comb
    begin
        length_next = length_reg;
        if (len_clear)
        begin
            length_next = '0;
        end
        else if (push)
        begin
            length_next = s_last ? '0 : length_reg + LEN_W'(8);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
        end
        else
        begin
            length_reg <= length_next;
        end
    end

endmodule

### src/sip_queue.sv
// Short queue of message blocks between the front and back parts.
module sip_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sip_pkg::blk_t      push_blk,
    input  logic               pop,
    output logic               full,
    output sip_pkg::q_status_t status
);
    import sip_pkg::*;

    blk_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_pop;

    assign full = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign status.head = entry_reg[rd_ptr_reg];
    assign do_pop = pop && !status.empty;

    // Payload storage, no reset needed.
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[wr_ptr_reg] <= push_blk;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if ((push && !full) && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!(push && !full) && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### src/sip_core.sv
// Back part: configuration registers, the shared SipRound unit and the result register.
module sip_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sip_pkg::cfg_wr_t           cfg,
    input  sip_pkg::q_status_t         q_status,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [sip_pkg::WORD_W-1:0] out_hash
);
    import sip_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMP,
        ST_FIN
    } state_t;

    state_t                 state_reg, state_next;
    lanes_t                 lanes_reg, lanes_next;
    logic [63:0]            key_low_reg, key_low_next;
    logic [63:0]            key_high_reg, key_high_next;
    logic [CFG_ROUND_W-1:0] comp_rounds_reg, comp_rounds_next;
    logic [CFG_ROUND_W-1:0] fin_rounds_reg, fin_rounds_next;
    logic [ROUND_W-1:0]     rem_reg, rem_next;
    logic [WORD_W-1:0]      m_reg, m_next;
    logic                   last_reg, last_next;
    logic                   out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]      hash_reg, hash_next;
    lanes_t                 lanes_round;
    lanes_t                 work;

    assign lanes_round = sip_round(lanes_reg);
    assign out_valid = out_valid_reg;
    assign out_hash = hash_reg;

    // Sequencer over message blocks, then configuration writes.
    always_comb
    begin
        state_next = state_reg;
        lanes_next = lanes_reg;
        key_low_next = key_low_reg;
        key_high_next = key_high_reg;
        comp_rounds_next = comp_rounds_reg;
        fin_rounds_next = fin_rounds_reg;
        rem_next = rem_reg;
        m_next = m_reg;
        last_next = last_reg;
        hash_next = hash_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        pop = 1'b0;
        work = (rem_reg != '0) ? lanes_round : lanes_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Take the next block and mix it into v3.
                if (!q_status.empty)
                begin
                    pop = 1'b1;
                    m_next = q_status.head.word;
                    last_next = q_status.head.last;
                    lanes_next.v3 = lanes_reg.v3 ^ q_status.head.word;
                    rem_next = sat_rounds(comp_rounds_reg);
                    state_next = ST_COMP;
                end
            end
            ST_COMP:
            begin
                // Compression rounds; the last one also folds the block into v0, and on a final block the mark into v2.
                if (rem_reg > ROUND_W'(1))
                begin
                    lanes_next = lanes_round;
                    rem_next = rem_reg - 1'b1;
                end
                else
                begin
                    work.v0 = work.v0 ^ m_reg;
                    if (last_reg)
                    begin
                        work.v2 = work.v2 ^ FINAL_MARK;
                        rem_next = sat_rounds(fin_rounds_reg);
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        rem_next = '0;
                        state_next = ST_IDLE;
                    end
                    lanes_next = work;
                end
            end
            ST_FIN:
            begin
                // Finalization rounds; the result waits for a free output register.
                if (rem_reg > ROUND_W'(1))
                begin
                    lanes_next = lanes_round;
                    rem_next = rem_reg - 1'b1;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    hash_next = work.v0 ^ work.v1 ^ work.v2 ^ work.v3;
                    out_valid_next = 1'b1;
                    lanes_next = lanes_init(key_low_reg, key_high_reg);
                    rem_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Configuration writes; a key write reloads the lanes.
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_KEY_LOW:
                begin
                    key_low_next = cfg.data;
                    lanes_next = lanes_init(cfg.data, key_high_reg);
                end
                REG_KEY_HIGH:
                begin
                    key_high_next = cfg.data;
                    lanes_next = lanes_init(key_low_reg, cfg.data);
                end
                REG_COMP_ROUNDS:
                begin
                    comp_rounds_next = cfg.data[CFG_ROUND_W-1:0];
                end
                REG_FIN_ROUNDS:
                begin
                    fin_rounds_next = cfg.data[CFG_ROUND_W-1:0];
                end
                default:
                begin
                    key_low_next = key_low_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lanes_reg <= lanes_init('0, '0);
            key_low_reg <= '0;
            key_high_reg <= '0;
            comp_rounds_reg <= CFG_ROUND_W'(2);
            fin_rounds_reg <= CFG_ROUND_W'(4);
            rem_reg <= '0;
            last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            m_reg <= '0;
            hash_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lanes_reg <= lanes_next;
            key_low_reg <= key_low_next;
            key_high_reg <= key_high_next;
            comp_rounds_reg <= comp_rounds_next;
            fin_rounds_reg <= fin_rounds_next;
            rem_reg <= rem_next;
            last_reg <= last_next;
            out_valid_reg <= out_valid_next;
            m_reg <= m_next;
            hash_reg <= hash_next;
        end
    end

endmodule

### src/sip_checker.sv
// Port-level checker for the SipHash top level, bound to it below.
`include "assert_macros.svh"

module sip_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           s_axis_tlast,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [sip_pkg::WORD_W-1:0]     m_axis_tdata
);
    import sip_pkg::*;

    logic [7:0] pending_reg;
    logic       last_in;
    logic       beat_out;

    assign last_in = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign beat_out = m_axis_tvalid && m_axis_tready;

    // Messages ended at the input and not yet answered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (last_in && !beat_out)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (!last_in && beat_out)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    `SIP_ASSERT(no_unrequested_hash, clk, rst_n, m_axis_tvalid |-> (pending_reg != 8'd0), "hash without a finished message")
    `SIP_ASSERT_NEXT(no_instant_hash, clk, rst_n, last_in && (pending_reg == 8'd0), !m_axis_tvalid, "hash appeared in the cycle after the final beat")
    `SIP_ASSERT_NEXT(out_valid_holds, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result valid dropped while stalled")
    `SIP_ASSERT_NEXT(out_data_holds, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result data changed while stalled")

endmodule

bind siphash_keyed_hash_top sip_checker u_sip_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
